// File: design/maf_pkg.sv
// Shared constants, types and helpers of the moving average filter.
package maf_pkg;

   localparam int WINDOW_MAX  = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int WL_BITS     = 7;
   localparam int SLOT_BITS   = $clog2(WINDOW_MAX);
   localparam int COUNT_BITS  = $clog2(WINDOW_MAX + 1);
   localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
   localparam int STEP_BITS   = $clog2(SUM_BITS + 1);

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;
   typedef logic [SUM_BITS-1:0]           mag_type;
   typedef logic [SLOT_BITS-1:0]          slot_type;
   typedef logic [COUNT_BITS-1:0]         count_type;
   typedef logic [WL_BITS-1:0]            wl_type;
   typedef logic [STEP_BITS-1:0]          step_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WINDOW_LENGTH = 1'b0
   } csr_index_type;

   localparam wl_type WL_RESET = WL_BITS'(4);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIV,
      ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic take_item;
      logic clear_run;
      logic read_old;
      logic update;
      logic div_start;
      logic load_out;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic emit;
      logic div_done;
   } status_type;

   // zero acts as one, anything above the store depth acts as the depth
   function automatic count_type effective_length(input wl_type wl);
      count_type len;
      if (wl == '0) begin
         len = COUNT_BITS'(1);
      end else if (int'(wl) > WINDOW_MAX) begin
         len = COUNT_BITS'(WINDOW_MAX);
      end else begin
         len = COUNT_BITS'(wl);
      end
      return len;
   endfunction

endpackage

// File: design/maf_channels.sv
// Request and response channel interfaces of the moving average filter.
interface maf_req_if import maf_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink (input valid, input sample, input restart, output ready);
endinterface

interface maf_rsp_if import maf_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type average;

   modport source (output valid, output average, input ready);
   modport sink (input valid, input average, output ready);
endinterface

// File: design/maf_div.sv
// Serial restoring divider: signed window sum by window length, one bit a cycle.
module maf_div import maf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  sum_type    dividend,
   input  count_type  divisor,
   output logic       done,
   output sample_type quotient
);

   logic      busy_ff, busy_in;
   logic      done_ff, done_in;
   logic      neg_ff, neg_in;
   step_type  step_ff, step_in;
   count_type rem_ff, rem_in;
   mag_type   quo_ff, quo_in;

   logic [COUNT_BITS:0] shifted;
   logic [COUNT_BITS:0] trial;
   mag_type             signed_quo;

   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_BITS-1]};
      trial   = shifted - {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[SUM_BITS-1];
         step_in = STEP_BITS'(SUM_BITS);
         rem_in  = '0;
         quo_in  = dividend[SUM_BITS-1] ? mag_type'(~dividend + 1'b1) : mag_type'(dividend);
      end else if (busy_ff) begin
         // restore when the trial subtraction goes below zero
         if (shifted >= {1'b0, divisor}) begin
            rem_in = trial[COUNT_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[COUNT_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign signed_quo = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = sample_type'(signed_quo[SAMPLE_BITS-1:0]);
   assign done       = done_ff;

endmodule

// File: design/maf_datapath.sv
// Datapath: history ring, running sum, run counters, divider and result register.
module maf_datapath import maf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  count_type  len,
   input  sample_type req_sample,
   input  logic       req_restart,
   output sample_type average
);

   sample_type history [WINDOW_MAX];

   sample_type sample_ff, sample_in;
   sample_type old_ff;
   sum_type    sum_ff, sum_in;
   slot_type   slot_ff, slot_in;
   count_type  seen_ff, seen_in;
   sample_type average_ff, average_in;

   slot_type   old_slot;
   logic       full;
   sum_type    sample_ext;
   sum_type    old_ext;
   logic       div_done;
   sample_type quotient;

   assign old_slot   = slot_ff - len[SLOT_BITS-1:0];
   assign full       = (seen_ff >= len);
   assign sample_ext = {{(SUM_BITS-SAMPLE_BITS){sample_ff[SAMPLE_BITS-1]}}, sample_ff};
   assign old_ext    = {{(SUM_BITS-SAMPLE_BITS){old_ff[SAMPLE_BITS-1]}}, old_ff};

   always_comb begin
      sample_in  = sample_ff;
      sum_in     = sum_ff;
      slot_in    = slot_ff;
      seen_in    = seen_ff;
      average_in = average_ff;
      if (cmd.take_item) begin
         sample_in = req_sample;
      end
      if (cmd.clear_run || (cmd.take_item && req_restart)) begin
         sum_in  = '0;
         slot_in = '0;
         seen_in = '0;
      end
      if (cmd.update) begin
         // drop the leaving sample once the window is full, add the new one
         sum_in  = (full ? (sum_ff - old_ext) : sum_ff) + sample_ext;
         slot_in = slot_ff + 1'b1;
         seen_in = full ? seen_ff : (seen_ff + 1'b1);
      end
      if (cmd.load_out) begin
         average_in = quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         history[slot_ff] <= sample_ff;
      end
      if (cmd.read_old) begin
         old_ff <= history[old_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         slot_ff <= '0;
         seen_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         slot_ff <= slot_in;
         seen_ff <= seen_in;
      end
      sample_ff  <= sample_in;
      average_ff <= average_in;
   end

   maf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_in),
      .divisor  (len),
      .done     (div_done),
      .quotient (quotient)
   );

   assign status.emit     = full || ((seen_ff + 1'b1) == len);
   assign status.div_done = div_done;
   assign average         = average_ff;

endmodule

// File: design/maf_ctrl.sv
// Controller: one request through read, update, and if due divide and result.
module maf_ctrl import maf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.clear_run = csr_write;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read_old = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.emit) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/moving_average_filter.sv
// Top level of the moving average filter: channels, register port and submodules.
//
//   channel   direction   handshake         payload
//   req       in          valid/ready       sample (s16), restart (1)
//   rsp       out         valid/ready       average (s16)
//   csr       in          APB psel/penable  window_length (u7) at byte address 0
//
// A request passes the idle, read and update states, and the divide and
// result states if it has a result: the serial divider retires one quotient
// bit per cycle over the 22-bit window sum. Reset is synchronous, active
// high; it clears the run (sum, ring position, fill count) and sets
// window_length to 4. The history ring needs no clearing: an entry is read
// only after it is written in the current run. A held result stalls only the
// next result; a new request is taken while the previous result waits on rsp.
module moving_average_filter import maf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   maf_req_if.sink                  req,
   maf_rsp_if.source                rsp,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   wl_type     window_length_ff, window_length_in;
   logic       hit_window_length;
   logic       csr_write;
   count_type  len;
   cmd_type    cmd;
   status_type status;

   // decode on the word index; the low byte-lane bits do not select
   assign hit_window_length = (paddr[CSR_ADDR_BITS-1:2] == CSR_WINDOW_LENGTH);
   assign csr_write         = psel && penable && pwrite && hit_window_length;
   assign pready            = 1'b1;

   always_comb begin
      window_length_in = window_length_ff;
      if (csr_write) begin
         window_length_in = pwdata[WL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WL_RESET;
      end else begin
         window_length_ff <= window_length_in;
      end
   end

   // read back the raw register, not the clamped length
   assign prdata = hit_window_length ? CSR_DATA_BITS'(window_length_ff) : '0;

   // clamp zero up to one and oversize down to the ring depth
   assign len = effective_length(window_length_ff);

   maf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   maf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .len         (len),
      .req_sample  (req.sample),
      .req_restart (req.restart),
      .average     (rsp.average)
   );

endmodule
